// ===== design/lmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_pkg
// Shared constants, register codes and stage types of the 3x3 local maximum
// filter.
// ----------------------------------------------------------------------------
package lmf_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned PixelW   = 8;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(1024);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(3);
  localparam logic [WidthW-1:0]  WidthMin    = WidthW'(3);
  localparam logic [WidthW-1:0]  WidthMax    = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightMin   = HeightW'(3);
  localparam logic [ColW-1:0]    FirstCol    = ColW'(2);
  localparam logic [HeightW-1:0] FirstRow    = HeightW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              row_last;
    logic              frame_last;
    logic [PixelW-1:0] pixel;
    logic [ColW-1:0]   col;
  } lmf_s1_t;

  function automatic logic [PixelW-1:0] max2(input logic [PixelW-1:0] a,
                                             input logic [PixelW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== design/lmf_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_intf
// Valid/ready channels of the filter: pixel input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface lmf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [lmf_pkg::PixelW-1:0]    pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lmf_res_if;
  logic                          valid;
  logic                          ready;
  logic [lmf_pkg::PixelW-1:0]    local_max;
  logic                          row_last;
  logic                          frame_last;
  modport source (output valid, output local_max, output row_last,
                  output frame_last, input ready);
  modport sink   (input valid, input local_max, input row_last,
                  input frame_last, output ready);
endinterface

interface lmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lmf_pkg::CfgIdxW-1:0]   index;
  logic [lmf_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lmf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/lmf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_ctrl
// Configuration registers, raster position counters and the stage register
// that pairs each pixel with its line-store read.
// ----------------------------------------------------------------------------
module lmf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [lmf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lmf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          pix_valid_i,
  input  wire logic [lmf_pkg::PixelW-1:0]    pix_i,
  output logic                               pix_ready_o,
  input  wire logic                          s1_adv_i,
  output logic                               rd_en_o,
  output logic      [lmf_pkg::ColW-1:0]      rd_addr_o,
  output lmf_pkg::lmf_s1_t                   s1_o
);
  import lmf_pkg::*;

  logic [WidthW-1:0]  width_q, width_d;
  logic [HeightW-1:0] height_q, height_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  lmf_s1_t            s1_q, s1_d;
  logic [WidthW-1:0]  eff_w, wm1;
  logic [HeightW-1:0] eff_h, hm1;
  logic               accept, rlast, flast;

  assign pix_ready_o = !s1_q.valid || s1_adv_i;
  assign accept      = pix_valid_i && pix_ready_o;
  assign rd_en_o     = accept;
  assign rd_addr_o   = col_q;
  assign s1_o        = s1_q;

  always_comb begin
    priority if (width_q < WidthMin) begin
      eff_w = WidthMin;
    end else if (width_q > WidthMax) begin
      eff_w = WidthMax;
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < HeightMin) ? HeightMin : height_q;
    wm1   = eff_w - WidthW'(1);
    hm1   = eff_h - HeightW'(1);
    rlast = {{(WidthW-ColW){1'b0}}, col_q} >= wm1;
    flast = rlast && (row_q >= hm1);
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WIDTH:  width_d  = cfg_data_i[WidthW-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[HeightW-1:0];
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    s1_d  = s1_q;
    if (accept) begin
      if (rlast) begin
        col_d = '0;
        row_d = flast ? '0 : row_q + HeightW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
      s1_d.valid      = 1'b1;
      s1_d.emit       = (col_q >= FirstCol) && (row_q >= FirstRow);
      s1_d.row_last   = rlast;
      s1_d.frame_last = flast;
      s1_d.pixel      = pix_i;
      s1_d.col        = col_q;
    end else if (s1_adv_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      s1_q     <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      s1_q     <= s1_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/lmf_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_window
// Sliding 3x3 window kept as column maxima, line-store write-back and the
// output register.
// ----------------------------------------------------------------------------
module lmf_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lmf_pkg::lmf_s1_t           s1_i,
  input  wire logic [lmf_pkg::PixelW-1:0] up2_i,
  input  wire logic [lmf_pkg::PixelW-1:0] up1_i,
  input  wire logic                       res_ready_i,
  output logic                            s1_adv_o,
  output logic                            wr_en_o,
  output logic      [lmf_pkg::ColW-1:0]   wr_addr_o,
  output logic      [lmf_pkg::PixelW-1:0] older_wdata_o,
  output logic      [lmf_pkg::PixelW-1:0] newer_wdata_o,
  output logic                            res_valid_o,
  output logic      [lmf_pkg::PixelW-1:0] local_max_o,
  output logic                            row_last_o,
  output logic                            frame_last_o
);
  import lmf_pkg::*;

  logic [PixelW-1:0] cm1_q, cm2_q, colmax, best;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] max_q;
  logic              rlast_q, flast_q;

  assign s1_adv_o      = s1_i.valid && (!s1_i.emit || !out_valid_q || res_ready_i);
  assign wr_en_o       = s1_adv_o;
  assign wr_addr_o     = s1_i.col;
  assign older_wdata_o = up1_i;
  assign newer_wdata_o = s1_i.pixel;

  assign colmax = max2(max2(up2_i, up1_i), s1_i.pixel);
  assign best   = max2(max2(cm2_q, cm1_q), colmax);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv_o && s1_i.emit) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cm1_q       <= '0;
      cm2_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_adv_o) begin
        cm2_q <= cm1_q;
        cm1_q <= colmax;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o && s1_i.emit) begin
      max_q   <= best;
      rlast_q <= s1_i.row_last;
      flast_q <= s1_i.frame_last;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign local_max_o  = max_q;
  assign row_last_o   = rlast_q;
  assign frame_last_o = flast_q;

endmodule
`default_nettype wire

// ===== design/local_max_3x3_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: a pixel is held in the stage register, then its result in the output register.
// Throughput: one pixel per cycle unless the output stalls; a pixel reads both
// line-store RAMs on transfer and writes them back as the window advances.
// Reset: counters, window and output valid cleared, image_width 1024,
// image_height 3; line-store RAMs are not cleared.
// ----------------------------------------------------------------------------
// local_max_3x3_filter_core
// Valid-only stride-1 3x3 maximum filter over a raster pixel stream.
// ----------------------------------------------------------------------------
module local_max_3x3_filter_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lmf_pix_if.sink    pix_i,
  lmf_res_if.source  res_o,
  lmf_cfg_if.sink    cfg_i
);
  import lmf_pkg::*;

  lmf_s1_t           s1;
  logic              s1_adv, rd_en, wr_en;
  logic [ColW-1:0]   rd_addr, wr_addr;
  logic [PixelW-1:0] up2, up1, older_wdata, newer_wdata;

  assign cfg_i.ready = 1'b1;

  lmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .pix_valid_i (pix_i.valid),
    .pix_i       (pix_i.pixel),
    .pix_ready_o (pix_i.ready),
    .s1_adv_i    (s1_adv),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .s1_o        (s1)
  );

  lmf_ram #(.Width(PixelW), .Depth(MaxWidth)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (older_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (up2)
  );

  lmf_ram #(.Width(PixelW), .Depth(MaxWidth)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (newer_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (up1)
  );

  lmf_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_i          (s1),
    .up2_i         (up2),
    .up1_i         (up1),
    .res_ready_i   (res_o.ready),
    .s1_adv_o      (s1_adv),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .older_wdata_o (older_wdata),
    .newer_wdata_o (newer_wdata),
    .res_valid_o   (res_o.valid),
    .local_max_o   (res_o.local_max),
    .row_last_o    (res_o.row_last),
    .frame_last_o  (res_o.frame_last)
  );

endmodule
`default_nettype wire

// ===== design/lmf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmf_checker
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module lmf_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       pix_valid_i,
  input wire logic                       pix_ready_i,
  input wire logic                       res_valid_i,
  input wire logic                       res_ready_i,
  input wire logic [lmf_pkg::PixelW-1:0] local_max_i,
  input wire logic                       row_last_i,
  input wire logic                       frame_last_i
);

  logic pix_xfer;
  assign pix_xfer = pix_valid_i && pix_ready_i;

  a_frame_implies_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (!frame_last_i || row_last_i))
    else $error("frame_last without row_last");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> pix_ready_i)
    else $error("pixel input stalled with empty output");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(pix_xfer, 2))
    else $error("result appeared without a pixel transfer two cycles before");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(local_max_i) && $stable(row_last_i) &&
       $stable(frame_last_i)))
    else $error("stalled result changed");

endmodule

bind local_max_3x3_filter_core lmf_checker u_lmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pix_valid_i  (pix_i.valid),
  .pix_ready_i  (pix_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .local_max_i  (res_o.local_max),
  .row_last_i   (res_o.row_last),
  .frame_last_i (res_o.frame_last)
);
`default_nettype wire
